@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the k-nearest-neighbor search RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BFKS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BFKS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bfks_pkg.sv @@
// Shared types and constants of the brute-force k-nearest-neighbor search unit.
// Used by the top level, bfks_dist and bfks_cell; depends on nothing.
package bfks_pkg;

    // Default sizes of the stores and the datapath.
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_GROUPS_DEF = 16;
    localparam int K_MAX_DEF      = 16;
    localparam int LANES_DEF      = 4;

    // Fixed field widths.
    localparam int COMP_W   = 16;
    localparam int IN_COMPS = 4;
    localparam int ID_W     = 32;
    localparam int DIST_W   = 42;
    localparam int STAT_W   = 3;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    // One lane term: a 17-bit difference squared or a negated 16x16 product.
    localparam int TERM_W   = 35;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_NEIGHBOR  = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_LEN_ERROR = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METRIC      = 2'd0,
        CFG_TOP_K       = 2'd1,
        CFG_GROUP_COUNT = 2'd2
    } cfg_index_t;

    // Input kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // One (distance, id) candidate held by a cell of the ranking chain.
    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] distance;
        logic [ID_W-1:0]          id;
    } entry_t;

    // Control broadcast to every cell of the ranking chain.
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/brute_force_knn_search_unit.sv @@
// Top level of the brute-force k-nearest-neighbor search unit.
// Depends on bfks_pkg, bfks_ram, bfks_dist, bfks_cell and assert_macros.svh.
//
// Usage:
//   Input stream (s_axis_*): one group of four Q7.8 components per request,
//   tuser = kind (insert or query), tlast = last group of the vector, tdata =
//   point id and the components. Output stream (m_axis_*): tuser = status,
//   tlast = last result of the vector, tdata = result id and distance.
//   Configuration (cfg_*): metric, top_k and group_count, written while idle.
// Sequence:
//   Non-final groups are counted and buffered as they arrive. After a final insert
//   group, the unused groups of the new slot are zeroed one per cycle through the
//   vector store write port, then the status is sent. A final query group
//   starts a scan of the vector store one group per cycle, bound by the
//   single store read port; the pipeline then drains and the neighbors are
//   returned nearest first, each held while the receiver stalls.
//   Errors and an empty store answer with a status result.
// Reset clears the store count, the group counter and the ranking chain;
//   store contents stay undefined until written.
// A stalled receiver holds the output register, and the unit waits with it;
//   no result is dropped.
`include "assert_macros.svh"

module brute_force_knn_search_unit #(
    parameter int MAX_POINTS = bfks_pkg::MAX_POINTS_DEF,
    parameter int MAX_GROUPS = bfks_pkg::MAX_GROUPS_DEF,
    parameter int K_MAX      = bfks_pkg::K_MAX_DEF,
    parameter int LANES      = bfks_pkg::LANES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: point_id[31:0], component_0[47:32], component_1[63:48],
    //        component_2[79:64], component_3[95:80]
    input  logic [95:0]                    s_axis_tdata,
    // tuser: kind[0]
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: result_id[31:0], result_distance[73:32], zero fill[79:74]
    output logic [79:0]                    m_axis_tdata,
    // tuser: status[2:0]
    output logic [bfks_pkg::STAT_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [bfks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfks_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CW    = bfks_pkg::COMP_W;
    localparam int VW    = LANES * CW;
    localparam int IDW   = bfks_pkg::ID_W;
    localparam int DW    = bfks_pkg::DIST_W;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int GI_W  = $clog2(MAX_GROUPS + 1);
    localparam int QA_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int IDA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int VDEP  = MAX_POINTS * MAX_GROUPS;
    localparam int AW    = (VDEP > 1) ? $clog2(VDEP) : 1;
    localparam int KW    = $clog2(K_MAX + 1);
    localparam int DRAIN_CYCLES = 6;
    localparam int DRW   = $clog2(DRAIN_CYCLES + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_ZERO  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_EMIT  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic                     metric_reg;
    logic [bfks_pkg::CFG_W-1:0] top_k_reg;
    logic [bfks_pkg::CFG_W-1:0] group_count_reg;

    // Control state.
    logic [GI_W-1:0]  gi_reg, gi_next;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    store_base_reg, store_base_next;
    logic [GI_W-1:0]  zg_reg, zg_next;
    logic [GI_W-1:0]  len_reg, len_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [CNT_W-1:0] scan_p_reg, scan_p_next;
    logic [GI_W-1:0]  scan_g_reg, scan_g_next;
    logic [AW-1:0]    scan_base_reg, scan_base_next;
    logic [DRW-1:0]   drain_reg, drain_next;
    bfks_pkg::status_t resp_reg, resp_next;

    // Scan issue flags, aligned with the registered store read data.
    logic             iss_valid_reg;
    logic             iss_first_reg;
    logic             iss_last_reg;
    logic [VW-1:0]    q_reg;

    // Query buffer.
    logic [VW-1:0]    qbuf [MAX_GROUPS];

    // Output register.
    logic             out_valid_reg, out_valid_next;
    bfks_pkg::status_t out_status_reg, out_status_next;
    logic [IDW-1:0]   out_id_reg, out_id_next;
    logic signed [DW-1:0] out_dist_reg, out_dist_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    // Memory ports.
    logic             vec_we;
    logic [AW-1:0]    vec_waddr;
    logic [VW-1:0]    vec_wdata;
    logic [VW-1:0]    vec_rdata;
    logic             id_we;
    logic [IDW-1:0]   id_rdata;

    // Input decode.
    logic             in_acc;
    logic [VW-1:0]    in_vec;
    logic             gi_in_range;
    logic [GI_W-1:0]  gi_after;
    logic             err_after;
    logic             mismatch;
    logic [KW-1:0]    k_clamped;

    // Distance unit and ranking chain.
    logic             dist_valid;
    bfks_pkg::entry_t dist_entry;
    bfks_pkg::cell_ctrl_t cell_ctrl;
    bfks_pkg::entry_t chain [K_MAX+1];
    logic             less_chain [K_MAX+1];
    logic [K_MAX-1:0] cell_vld;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_LOAD);

    // Map the input components onto the lanes; lanes past four hold zero.
    always_comb
    begin
        in_vec = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (l < bfks_pkg::IN_COMPS)
            begin
                in_vec[l*CW +: CW] = s_axis_tdata[IDW + l*CW +: CW];
            end
        end
    end

    assign gi_in_range = (gi_reg < GI_W'(MAX_GROUPS));
    assign gi_after    = gi_in_range ? GI_W'(gi_reg + 1'b1) : gi_reg;
    assign err_after   = err_reg || !gi_in_range;
    assign mismatch    = err_after || (8'(gi_after) != 8'(group_count_reg));

    // Clamp top_k into one to K_MAX.
    always_comb
    begin
        if (top_k_reg == '0)
        begin
            k_clamped = KW'(1);
        end
        else if (8'(top_k_reg) > 8'(K_MAX))
        begin
            k_clamped = KW'(K_MAX);
        end
        else
        begin
            k_clamped = KW'(top_k_reg);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg      <= 1'b0;
            top_k_reg       <= bfks_pkg::CFG_W'(1);
            group_count_reg <= bfks_pkg::CFG_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfks_pkg::CFG_METRIC:      metric_reg      <= cfg_data[0];
                bfks_pkg::CFG_TOP_K:       top_k_reg       <= cfg_data;
                bfks_pkg::CFG_GROUP_COUNT: group_count_reg <= cfg_data;
                default:                   metric_reg      <= metric_reg;
            endcase
        end
    end

    // Query buffer: every group within MAX_GROUPS is kept here as it arrives.
    always_ff @(posedge clk)
    begin
        if (in_acc && gi_in_range)
        begin
            qbuf[gi_reg[QA_W-1:0]] <= in_vec;
        end
        q_reg <= qbuf[scan_g_reg[QA_W-1:0]];
    end

    // Vector store writes: while the store has room, incoming groups go straight
    // into the next free slot; an insert then zeroes the slot's unused groups.
    always_comb
    begin
        vec_we    = 1'b0;
        vec_waddr = store_base_reg + AW'(gi_reg);
        vec_wdata = in_vec;
        if (state_reg == S_ZERO)
        begin
            vec_we    = 1'b1;
            vec_waddr = store_base_reg + AW'(zg_reg);
            vec_wdata = '0;
        end
        else if (in_acc && gi_in_range && (count_reg < CNT_W'(MAX_POINTS)))
        begin
            vec_we = 1'b1;
        end
    end

    assign id_we = in_acc && s_axis_tlast && !mismatch &&
                   (s_axis_tuser == bfks_pkg::KIND_INSERT) &&
                   (count_reg < CNT_W'(MAX_POINTS));

    bfks_ram #(
        .WIDTH(VW),
        .DEPTH(VDEP)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .raddr (scan_base_reg + AW'(scan_g_reg)),
        .rdata (vec_rdata)
    );

    bfks_ram #(
        .WIDTH(IDW),
        .DEPTH(MAX_POINTS)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (count_reg[IDA_W-1:0]),
        .wdata (s_axis_tdata[IDW-1:0]),
        .raddr (scan_p_reg[IDA_W-1:0]),
        .rdata (id_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        gi_next         = gi_reg;
        err_next        = err_reg;
        count_next      = count_reg;
        store_base_next = store_base_reg;
        zg_next         = zg_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        scan_p_next     = scan_p_reg;
        scan_g_next     = scan_g_reg;
        scan_base_next  = scan_base_reg;
        drain_next      = drain_reg;
        resp_next       = resp_reg;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.insert = dist_valid;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_dist_next   = out_dist_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (!s_axis_tlast)
                    begin
                        gi_next  = gi_after;
                        err_next = err_after;
                    end
                    else
                    begin
                        gi_next  = '0;
                        err_next = 1'b0;
                        if (mismatch)
                        begin
                            resp_next  = bfks_pkg::ST_LEN_ERROR;
                            state_next = S_RESP;
                        end
                        else if (s_axis_tuser == bfks_pkg::KIND_QUERY)
                        begin
                            if (count_reg == '0)
                            begin
                                resp_next  = bfks_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cell_ctrl.clear = 1'b1;
                                len_next        = gi_after;
                                k_next          = k_clamped;
                                scan_p_next     = '0;
                                scan_g_next     = '0;
                                scan_base_next  = '0;
                                state_next      = S_SCAN;
                            end
                        end
                        else if (count_reg >= CNT_W'(MAX_POINTS))
                        begin
                            resp_next  = bfks_pkg::ST_FULL;
                            state_next = S_RESP;
                        end
                        else if (gi_after == GI_W'(MAX_GROUPS))
                        begin
                            count_next      = CNT_W'(count_reg + 1'b1);
                            store_base_next = store_base_reg + AW'(MAX_GROUPS);
                            resp_next       = bfks_pkg::ST_INSERTED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            zg_next    = gi_after;
                            state_next = S_ZERO;
                        end
                    end
                end
            end

            S_ZERO:
            begin
                zg_next = GI_W'(zg_reg + 1'b1);
                if (zg_reg == GI_W'(MAX_GROUPS - 1))
                begin
                    count_next      = CNT_W'(count_reg + 1'b1);
                    store_base_next = store_base_reg + AW'(MAX_GROUPS);
                    resp_next       = bfks_pkg::ST_INSERTED;
                    state_next      = S_RESP;
                end
            end

            S_SCAN:
            begin
                if (scan_g_reg == GI_W'(len_reg - 1'b1))
                begin
                    scan_g_next    = '0;
                    scan_p_next    = CNT_W'(scan_p_reg + 1'b1);
                    scan_base_next = scan_base_reg + AW'(MAX_GROUPS);
                    if (CNT_W'(scan_p_reg + 1'b1) == count_reg)
                    begin
                        drain_next = DRW'(DRAIN_CYCLES);
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    scan_g_next = GI_W'(scan_g_reg + 1'b1);
                end
            end

            S_DRAIN:
            begin
                drain_next = DRW'(drain_reg - 1'b1);
                if (drain_reg == DRW'(1))
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bfks_pkg::ST_NEIGHBOR;
                    out_id_next     = chain[0].id;
                    out_dist_next   = chain[0].distance;
                    out_last_next   = !chain[1].valid;
                    cell_ctrl.shift = 1'b1;
                    if (!chain[1].valid)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_id_next     = '0;
                    out_dist_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            gi_reg         <= '0;
            err_reg        <= 1'b0;
            count_reg      <= '0;
            store_base_reg <= '0;
            zg_reg         <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            scan_p_reg     <= '0;
            scan_g_reg     <= '0;
            scan_base_reg  <= '0;
            drain_reg      <= '0;
            resp_reg       <= bfks_pkg::ST_EMPTY;
            iss_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gi_reg         <= gi_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            store_base_reg <= store_base_next;
            zg_reg         <= zg_next;
            len_reg        <= len_next;
            k_reg          <= k_next;
            scan_p_reg     <= scan_p_next;
            scan_g_reg     <= scan_g_next;
            scan_base_reg  <= scan_base_next;
            drain_reg      <= drain_next;
            resp_reg       <= resp_next;
            iss_valid_reg  <= (state_reg == S_SCAN);
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        iss_first_reg  <= (scan_g_reg == '0);
        iss_last_reg   <= (scan_g_reg == GI_W'(len_reg - 1'b1));
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_dist_reg   <= out_dist_next;
        out_last_reg   <= out_last_next;
    end

    bfks_dist #(
        .LANES      (LANES),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .metric    (metric_reg),
        .in_valid  (iss_valid_reg),
        .in_first  (iss_first_reg),
        .in_last   (iss_last_reg),
        .q_vec     (q_reg),
        .p_vec     (vec_rdata),
        .in_id     (id_rdata),
        .out_valid (dist_valid),
        .out_entry (dist_entry)
    );

    // Ranking chain: cell 0 holds the nearest pair.
    assign chain[K_MAX]   = '0;
    assign less_chain[0]  = 1'b0;

    for (genvar i = 0; i < K_MAX; i++)
    begin : g_cell
        logic                 prev_less;
        bfks_pkg::entry_t     prev_entry;
        logic                 cell_en;

        if (i == 0)
        begin : g_head
            assign prev_less  = less_chain[0];
            assign prev_entry = '0;
        end
        else
        begin : g_body
            assign prev_less  = less_chain[i];
            assign prev_entry = chain[i-1];
        end

        assign cell_en = (8'(i) < 8'(k_reg));

        bfks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .en         (cell_en),
            .cand       (dist_entry),
            .prev_less  (prev_less),
            .prev_entry (prev_entry),
            .next_entry (chain[i+1]),
            .less       (less_chain[i+1]),
            .entry      (chain[i])
        );

        assign cell_vld[i] = chain[i].valid;
    end

    // Output stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_dist_reg, out_id_reg};

    // Checks.
    `BFKS_ASSERT_IMP(a_status_last, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != bfks_pkg::ST_NEIGHBOR), m_axis_tlast,
        "status result without last mark")
    `BFKS_ASSERT_IMP(a_chain_packed, clk, rst_n, 1'b1,
        ((cell_vld >> 1) & ~cell_vld) == '0, "gap in ranking chain")
    `BFKS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(MAX_POINTS), "store count beyond capacity")
    `BFKS_ASSERT_IMP(a_dist_in_scan, clk, rst_n, dist_valid,
        (state_reg == S_SCAN) || (state_reg == S_DRAIN), "distance outside scan")

endmodule

@@ hw/rtl/bfks_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the vector store and the id store; depends on nothing.
module bfks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bfks_dist.sv @@
// Distance unit: accumulates squared L2 distance or negated dot product one
// group per cycle over three register stages. Depends on bfks_pkg.
module bfks_dist #(
    parameter int LANES      = bfks_pkg::LANES_DEF,
    parameter int MAX_GROUPS = bfks_pkg::MAX_GROUPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               metric,
    input  logic                               in_valid,
    input  logic                               in_first,
    input  logic                               in_last,
    input  logic [LANES*bfks_pkg::COMP_W-1:0]  q_vec,
    input  logic [LANES*bfks_pkg::COMP_W-1:0]  p_vec,
    input  logic [bfks_pkg::ID_W-1:0]          in_id,
    output logic                               out_valid,
    output bfks_pkg::entry_t                   out_entry
);

    localparam int CW     = bfks_pkg::COMP_W;
    localparam int TW     = bfks_pkg::TERM_W;
    localparam int DW     = bfks_pkg::DIST_W;
    localparam int RAW_W  = TW + $clog2(LANES * MAX_GROUPS + 1) + 1;
    localparam int ACC_W  = (RAW_W > DW + 1) ? RAW_W : DW + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [TW-1:0]    term_next [LANES];
    logic signed [TW-1:0]    term_reg  [LANES];
    logic                    s1_valid_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic [bfks_pkg::ID_W-1:0] s1_id_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    s2_done_reg;
    logic [bfks_pkg::ID_W-1:0] s2_id_reg;
    logic                    out_valid_reg;
    logic signed [DW-1:0]    out_dist_reg;
    logic [bfks_pkg::ID_W-1:0] out_id_reg;

    // Stage 1: a square and a product per lane, selected by the metric.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic signed [CW-1:0]   q;
            logic signed [CW-1:0]   p;
            logic signed [CW:0]     diff;
            logic signed [2*CW+1:0] sq;
            logic signed [2*CW-1:0] prod;
            q    = q_vec[l*CW +: CW];
            p    = p_vec[l*CW +: CW];
            diff = {q[CW-1], q} - {p[CW-1], p};
            sq   = diff * diff;
            prod = q * p;
            if (metric)
            begin
                term_next[l] = -TW'(prod);
            end
            else
            begin
                term_next[l] = TW'(sq);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            term_reg[l] <= term_next[l];
        end
        s1_first_reg <= in_first;
        s1_last_reg  <= in_last;
        s1_id_reg    <= in_id;
    end

    // Stage 2: lane sum added to the running total of the point.
    always_comb
    begin
        acc_next = s1_first_reg ? '0 : acc_reg;
        for (int l = 0; l < LANES; l++)
        begin
            acc_next = acc_next + ACC_W'(term_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        s2_id_reg <= s1_id_reg;
    end

    // Stage 3: saturate the finished total to the result width.
    always_ff @(posedge clk)
    begin
        if (acc_reg > SAT_HI)
        begin
            out_dist_reg <= DW'(SAT_HI);
        end
        else if (acc_reg < SAT_LO)
        begin
            out_dist_reg <= DW'(SAT_LO);
        end
        else
        begin
            out_dist_reg <= DW'(acc_reg);
        end
        out_id_reg <= s2_id_reg;
    end

    // Valid flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_done_reg   <= s1_valid_reg && s1_last_reg;
            out_valid_reg <= s2_done_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_entry.valid    = out_valid_reg;
    assign out_entry.distance = out_dist_reg;
    assign out_entry.id       = out_id_reg;

endmodule

@@ hw/rtl/bfks_cell.sv @@
// One cell of the ranking chain: holds one (distance, id) pair in rank order,
// takes a candidate or its upper neighbor's pair, and shifts out toward cell 0.
// Depends on bfks_pkg.
module bfks_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfks_pkg::cell_ctrl_t ctrl,
    input  logic                 en,
    input  bfks_pkg::entry_t     cand,
    input  logic                 prev_less,
    input  bfks_pkg::entry_t     prev_entry,
    input  bfks_pkg::entry_t     next_entry,
    output logic                 less,
    output bfks_pkg::entry_t     entry
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [bfks_pkg::DIST_W-1:0] dist_reg;
    logic signed [bfks_pkg::DIST_W-1:0] dist_next;
    logic [bfks_pkg::ID_W-1:0]         id_reg;
    logic [bfks_pkg::ID_W-1:0]         id_next;
    logic                              load;

    // The candidate ranks above this pair; an empty cell ranks below all.
    assign less = !valid_reg || (cand.distance < dist_reg) ||
                  ((cand.distance == dist_reg) && (cand.id < id_reg));

    // Next contents: clear, shift toward cell 0, or insertion in rank order.
    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        id_next    = id_reg;
        load       = 1'b0;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_entry.valid;
            dist_next  = next_entry.distance;
            id_next    = next_entry.id;
            load       = 1'b1;
        end
        else if (ctrl.insert && en && less)
        begin
            load = 1'b1;
            if (prev_less)
            begin
                valid_next = prev_entry.valid;
                dist_next  = prev_entry.distance;
                id_next    = prev_entry.id;
            end
            else
            begin
                valid_next = 1'b1;
                dist_next  = cand.distance;
                id_next    = cand.id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dist_reg <= dist_next;
            id_reg   <= id_next;
        end
    end

    assign entry.valid    = valid_reg;
    assign entry.distance = dist_reg;
    assign entry.id       = id_reg;

endmodule
